// File: sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue core and its cells.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int SIZE_W    = 16;
	localparam int VALUE_W   = 32;
	localparam int WORD_W    = SIZE_W + VALUE_W;

	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_ADD_FRONT = 2'd0,
		OP_ADD_BACK  = 2'd1,
		OP_REM_FRONT = 2'd2,
		OP_REM_BACK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Per-cycle commands broadcast to every cell of the chain
	typedef struct packed {
		logic push_front;  // take the left neighbor's word
		logic pop_front;   // take the right neighbor's word
		logic push_back;   // the cell at the fill count takes the new word
		logic pick_back;   // the last occupied cell loads its word on the return line
		logic walk;        // advance the return line one cell toward the front
	} ctl_t;

endpackage

// File: sv/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One slot of the deque chain: holds one word and one return-line stage.
// ----------------------------------------------------------------------------
module deq_cell import deq_pkg::*; #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  ctl_t             ctl,
	input  logic [CNT_W-1:0] cnt,
	input  word_t            new_word,
	input  word_t            left_word,
	input  word_t            right_word,
	input  word_t            right_ret,
	output word_t            word,
	output word_t            ret
);

	word_t data_q;
	word_t ret_q;
	logic  at_count;
	logic  at_last;

	assign at_count = (cnt == CNT_W'(INDEX));
	assign at_last  = (cnt == CNT_W'(INDEX + 1));

	// Front add shifts back, front removal shifts forward, back add loads at the count
	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			data_q <= left_word;
		end else if (ctl.pop_front) begin
			data_q <= right_word;
		end else if (ctl.push_back && at_count) begin
			data_q <= new_word;
		end
	end

	// Return line: carry the back word toward cell zero
	always_ff @(posedge clk) begin
		if (ctl.pick_back) begin
			ret_q <= at_last ? data_q : right_ret;
		end else if (ctl.walk) begin
			ret_q <= right_ret;
		end
	end

	assign word = data_q;
	assign ret  = ret_q;

endmodule

// File: sv/double_ended_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue built as a chain of storage cells.
// ----------------------------------------------------------------------------
// Usage:
//   Present opcode, entry_size and entry_value with start high; the word is
//   taken at a rising edge where start is high and busy is low. Each word
//   gives exactly one result, shown on status, removed_size and removed_value
//   for one cycle while done is high. The receiver cannot stall; results are
//   never held.
// Structure:
//   DEPTH cells form a row with the front entry always in cell zero. A front
//   add shifts every cell one place back, a front removal shifts one place
//   forward, a back add writes the cell at the fill count. A back removal
//   loads the last occupied word onto a return line that moves one cell per
//   cycle toward cell zero.
// Timing:
//   Adds and front removals: done in the cycle after acceptance, busy stays
//   low, so one word per cycle. Back removal: busy while the return line
//   walks the back word to cell zero, and done rises as busy falls. Refused
//   adds and empty removals are also done in the cycle after acceptance.
// Reset:
//   arst_n clears the fill count, the walk state and done. Cell contents are
//   not reset; only occupied cells are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue_core import deq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic [SIZE_W-1:0]  entry_size,
	input  logic [VALUE_W-1:0] entry_value,
	output logic               done,
	output logic [1:0]         status,
	output logic [SIZE_W-1:0]  removed_size,
	output logic [VALUE_W-1:0] removed_value
);

	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic {
		S_IDLE,
		S_WALK
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   rem_q;
	logic               done_q;
	status_t            status_q;
	word_t              removed_q;

	logic  accept;
	logic  full;
	logic  empty;
	op_t   op;
	word_t new_word;
	ctl_t  ctl;

	word_t cell_data [DEPTH];
	word_t cell_ret  [DEPTH];

	assign accept   = start && (state_q == S_IDLE);
	assign op       = op_t'(opcode);
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign new_word = {entry_size, entry_value};

	// Broadcast commands; refused adds and empty removals touch no cell
	always_comb begin
		ctl            = '0;
		ctl.push_front = accept && (op == OP_ADD_FRONT) && !full;
		ctl.push_back  = accept && (op == OP_ADD_BACK) && !full;
		ctl.pop_front  = accept && (op == OP_REM_FRONT) && !empty;
		ctl.pick_back  = accept && (op == OP_REM_BACK) && !empty;
		ctl.walk       = (state_q == S_WALK);
	end

	// Row of cells; ends see the new word in front and zero behind
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		word_t left_w;
		word_t right_w;
		word_t right_r;

		if (i == 0) begin : g_first
			assign left_w = new_word;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
			assign right_r = '0;
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
			assign right_r = cell_ret[i+1];
		end

		deq_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.cnt        (cnt_q),
			.new_word   (new_word),
			.left_word  (left_w),
			.right_word (right_w),
			.right_ret  (right_r),
			.word       (cell_data[i]),
			.ret        (cell_ret[i])
		);
	end

	// Control and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			rem_q     <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_DONE;
			removed_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						unique case (op)
							OP_ADD_FRONT, OP_ADD_BACK: begin
								done_q    <= 1'b1;
								removed_q <= '0;
								if (full) begin
									status_q <= ST_FULL;
								end else begin
									status_q <= ST_DONE;
									cnt_q    <= cnt_q + 1'b1;
								end
							end
							OP_REM_FRONT: begin
								done_q <= 1'b1;
								if (empty) begin
									status_q  <= ST_EMPTY;
									removed_q <= '0;
								end else begin
									status_q  <= ST_DONE;
									removed_q <= cell_data[0];
									cnt_q     <= cnt_q - 1'b1;
								end
							end
							OP_REM_BACK: begin
								if (empty) begin
									done_q    <= 1'b1;
									status_q  <= ST_EMPTY;
									removed_q <= '0;
								end else begin
									// hold off new words while the back word walks forward
									state_q <= S_WALK;
									rem_q   <= cnt_q - 1'b1;
									cnt_q   <= cnt_q - 1'b1;
								end
							end
						endcase
					end
				end
				S_WALK: begin
					if (rem_q == '0) begin
						done_q    <= 1'b1;
						status_q  <= ST_DONE;
						removed_q <= cell_ret[0];
						state_q   <= S_IDLE;
					end else begin
						rem_q <= rem_q - 1'b1;
					end
				end
			endcase
		end
	end

	assign busy          = (state_q == S_WALK);
	assign done          = done_q;
	assign status        = status_q;
	assign removed_size  = removed_q[WORD_W-1:VALUE_W];
	assign removed_value = removed_q[VALUE_W-1:0];

endmodule
